### rtl/ctq_pkg.sv
// Shared types and constants of the capture tachometer (quarter RPM).
// No dependencies; used by ctq_ctrl, ctq_dpath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ctq_pkg;

    localparam int CountWidth  = 16;
    localparam int PeriodWidth = 24;
    localparam int DivWidth    = 32;
    localparam int OvfWidth    = 8;
    localparam int CfgIdxWidth = 2;

    localparam logic [OvfWidth-1:0]    StopCount      = 8'd128;
    localparam logic [CountWidth-1:0]  FullScale      = 16'hFFFF;
    localparam logic [DivWidth-1:0]    RateNumReset   = 32'd480000000;
    localparam logic [PeriodWidth-1:0] MinPeriodReset = 24'd7325;
    localparam logic [CountWidth-1:0]  RampNumReset   = 16'd7325;

    typedef enum logic {
        OP_CAPTURE = 1'b0,
        OP_TICK    = 1'b1
    } event_op_t;

    typedef enum logic [1:0] {
        KIND_STOPPED  = 2'd0,
        KIND_RAMP     = 2'd1,
        KIND_OVER     = 2'd2,
        KIND_MEASURED = 2'd3
    } speed_kind_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_RATE_NUM   = 2'd0,
        CFG_MIN_PERIOD = 2'd1,
        CFG_RAMP_NUM   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } ctq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture_event;
        logic eval_start;
        logic div_step;
        logic load_out;
    } ctq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic last_step;
        logic out_free;
    } ctq_stat_t;

endpackage

`default_nettype wire

### rtl/ctq_ctrl.sv
// Sequencer of the capture tachometer: takes an event, evaluates, divides if needed, outputs.
// Depends on ctq_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module ctq_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire ctq_pkg::ctq_stat_t stat,
    output ctq_pkg::ctq_cmd_t       cmd
);
    import ctq_pkg::*;

    ctq_state_t state_reg;
    ctq_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = stat.need_div ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (stat.last_step) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready          = 1'b1;
                cmd.capture_event = s_tvalid;
            end
            ST_EVAL: cmd.eval_start = 1'b1;
            ST_DIV:  cmd.div_step   = 1'b1;
            ST_OUT:  cmd.load_out   = stat.out_free;
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_to_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture_event |=> state_reg == ST_EVAL)
        else $error("accepted event did not move to evaluation");

    a_div_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && stat.last_step) |=> state_reg == ST_OUT)
        else $error("divider finished but result was not staged");

    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture_event, cmd.eval_start, cmd.div_step, cmd.load_out}))
        else $error("more than one datapath command in a cycle");
`endif

endmodule

`default_nettype wire

### rtl/ctq_dpath.sv
// Datapath of the capture tachometer: event state, configuration, shared divider
// and output register. Depends on ctq_pkg; driven by ctq_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module ctq_dpath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ctq_pkg::ctq_cmd_t cmd,
    output ctq_pkg::ctq_stat_t     stat,
    input  wire logic              ev_op,
    input  wire logic [15:0]       ev_count,
    input  wire logic              cfg_valid,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    output logic [15:0]            out_qrpm,
    output logic [1:0]             out_kind,
    output logic                   out_valid,
    input  wire logic              out_ready
);
    import ctq_pkg::*;

    // Configuration registers.
    logic [DivWidth-1:0]    rate_num_reg;
    logic [PeriodWidth-1:0] min_period_reg;
    logic [CountWidth-1:0]  ramp_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_num_reg   <= RateNumReset;
            min_period_reg <= MinPeriodReset;
            ramp_num_reg   <= RampNumReset;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RATE_NUM:   rate_num_reg   <= cfg_data;
                CFG_MIN_PERIOD: min_period_reg <= cfg_data[PeriodWidth-1:0];
                CFG_RAMP_NUM:   ramp_num_reg   <= cfg_data[CountWidth-1:0];
                default: ;
            endcase
        end
    end

    // Event state.
    logic [OvfWidth-1:0]   ovf_reg, ovf_next;
    logic [CountWidth-1:0] last_reg, last_next;
    logic [CountWidth-1:0] plow_reg, plow_next;
    logic [OvfWidth-1:0]   phigh_reg, phigh_next;
    logic [OvfWidth:0]     ovf_inc;

    always_comb begin
        ovf_next   = ovf_reg;
        last_next  = last_reg;
        plow_next  = plow_reg;
        phigh_next = phigh_reg;
        ovf_inc    = {1'b0, ovf_reg} + {{OvfWidth{1'b0}}, 1'b1};
        if (cmd.capture_event) begin
            if (ev_op == OP_CAPTURE) begin
                plow_next  = ev_count - last_reg;
                // A wrap of the timer means one of the overflows is already
                // inside the 16-bit difference.
                phigh_next = (ev_count < last_reg) ? ovf_reg - 8'd1 : ovf_reg;
                ovf_next   = '0;
                last_next  = ev_count;
            end else begin
                ovf_next = (ovf_inc >= {1'b0, StopCount}) ? StopCount
                                                          : ovf_inc[OvfWidth-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg   <= StopCount;
            last_reg  <= '0;
            plow_reg  <= '0;
            phigh_reg <= '0;
        end else begin
            ovf_reg   <= ovf_next;
            last_reg  <= last_next;
            plow_reg  <= plow_next;
            phigh_reg <= phigh_next;
        end
    end

    // Speed rule on the updated state.
    logic [PeriodWidth-1:0] period;
    speed_kind_t            kind_sel;

    assign period = {phigh_reg, plow_reg};

    always_comb begin
        if (ovf_reg >= StopCount) begin
            kind_sel = KIND_STOPPED;
        end else if (ovf_reg > phigh_reg) begin
            kind_sel = KIND_RAMP;
        end else if (period < min_period_reg || period == '0) begin
            kind_sel = KIND_OVER;
        end else begin
            kind_sel = KIND_MEASURED;
        end
    end

    // Restoring divider, one quotient bit per cycle. The dividend register
    // shifts left and collects the quotient bits at the bottom.
    speed_kind_t             kind_reg;
    logic [DivWidth-1:0]     dvd_reg, dvd_next;
    logic [PeriodWidth-1:0]  rem_reg, rem_next;
    logic [PeriodWidth-1:0]  dvs_reg, dvs_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic [PeriodWidth:0]    shifted;
    logic [PeriodWidth+1:0]  trial;

    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        shifted  = {rem_reg, dvd_reg[DivWidth-1]};
        trial    = {1'b0, shifted} - {2'b00, dvs_reg};
        if (cmd.eval_start) begin
            rem_next = '0;
            cnt_next = '0;
            if (kind_sel == KIND_RAMP) begin
                dvd_next = {{(DivWidth-CountWidth){1'b0}}, ramp_num_reg};
                dvs_next = {{(PeriodWidth-OvfWidth){1'b0}}, ovf_reg};
            end else begin
                dvd_next = rate_num_reg;
                dvs_next = period;
            end
        end else if (cmd.div_step) begin
            cnt_next = cnt_reg + 5'd1;
            if (trial[PeriodWidth+1]) begin
                rem_next = shifted[PeriodWidth-1:0];
                dvd_next = {dvd_reg[DivWidth-2:0], 1'b0};
            end else begin
                rem_next = trial[PeriodWidth-1:0];
                dvd_next = {dvd_reg[DivWidth-2:0], 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (cmd.eval_start) begin
            kind_reg <= kind_sel;
        end
    end

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [15:0] qrpm_reg, qrpm_next;
    logic [1:0]  kind_out_reg, kind_out_next;

    always_comb begin
        case (kind_reg)
            KIND_STOPPED:  qrpm_next = '0;
            KIND_RAMP:     qrpm_next = dvd_reg[CountWidth-1:0];
            KIND_OVER:     qrpm_next = FullScale;
            KIND_MEASURED: qrpm_next = (dvd_reg[DivWidth-1:CountWidth] != '0)
                                       ? FullScale : dvd_reg[CountWidth-1:0];
            default:       qrpm_next = '0;
        endcase
        kind_out_next  = kind_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (cmd.load_out) begin
            qrpm_reg     <= qrpm_next;
            kind_out_reg <= kind_out_next;
        end
    end

    assign out_qrpm  = qrpm_reg;
    assign out_kind  = kind_out_reg;
    assign out_valid = out_valid_reg;

    assign stat.need_div  = (kind_sel == KIND_RAMP) || (kind_sel == KIND_MEASURED);
    assign stat.last_step = (cnt_reg == 5'd31);
    assign stat.out_free  = !out_valid_reg || out_ready;

`ifndef ASSERT_OFF
    a_ovf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg <= StopCount)
        else $error("overflow count above the stop value");

    a_stopped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && kind_out_reg == KIND_STOPPED) |-> qrpm_reg == '0)
        else $error("stopped result carries a nonzero speed");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

### rtl/capture_tachometer_qrpm_unit.sv
// Capture tachometer reporting speed in quarter RPM: every input transfer (a
// capture edge or a timer overflow tick) yields exactly one result transfer.
// An event that needs a division (measured speed or ramp-down bound) goes from
// evaluation through the shared restoring divider, which produces one quotient
// bit per cycle, to the output stage; stopped and over-range results skip the
// divider. One event is in work at a time; a new one is taken as soon as the
// previous result sits in the output register.
// Configuration writes are always accepted (cfg_ready is tied high).
// Depends on ctq_pkg, ctq_ctrl and ctq_dpath.
`timescale 1ns / 1ps
`default_nettype none

module capture_tachometer_qrpm_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] edge_stamp
    input  wire logic        s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] qrpm
    output logic [1:0]       m_tuser,   // [1:0] speed_kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import ctq_pkg::*;

    ctq_cmd_t  cmd;
    ctq_stat_t stat;

    assign cfg_ready = 1'b1;

    ctq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ctq_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .ev_op     (s_tuser),
        .ev_count  (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_qrpm  (m_tdata),
        .out_kind  (m_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for capture_tachometer_qrpm_unit: directed and random event streams,
// a cycle-free speed predictor, and a scoreboard fed by stream driver and monitor blocks.
// Depends on ctq_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import ctq_pkg::*;

    localparam logic [CfgIdxWidth-1:0] CfgUnused = 2'd3;

    typedef struct {
        event_op_t        op;
        logic [15:0]      cc;
    } tach_event_t;

    typedef struct {
        logic [15:0]      qrpm;
        speed_kind_t      kind;
    } speed_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // Predictor copy of the configuration and of the tachometer state.
    logic [31:0] rate_num;
    logic [23:0] min_per;
    logic [15:0] ramp_num;
    logic [7:0]  ovf_cnt;
    logic [15:0] last_cc;
    logic [15:0] per_low;
    logic [7:0]  per_high;

    tach_event_t pending_events[$];
    speed_t      expected_speeds[$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    logic [15:0] tach_timer     = '0;

    capture_tachometer_qrpm_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Applies one event to the predicted state and returns the speed it reports.
    function automatic speed_t predict_speed(input event_op_t op, input logic [15:0] cc);
        speed_t      res;
        logic [23:0] period;
        logic [31:0] quot;
        if (op == OP_CAPTURE) begin
            per_low  = cc - last_cc;
            per_high = (cc < last_cc) ? ovf_cnt - 8'd1 : ovf_cnt;
            ovf_cnt  = '0;
            last_cc  = cc;
        end else begin
            ovf_cnt = (ovf_cnt >= StopCount - 8'd1) ? StopCount : ovf_cnt + 8'd1;
        end
        if (ovf_cnt >= StopCount) begin
            res.qrpm = '0;
            res.kind = KIND_STOPPED;
        end else if (ovf_cnt > per_high) begin
            res.qrpm = ramp_num / {8'd0, ovf_cnt};
            res.kind = KIND_RAMP;
        end else begin
            period = {per_high, per_low};
            if (period < min_per || period == '0) begin
                res.qrpm = FullScale;
                res.kind = KIND_OVER;
            end else begin
                quot     = rate_num / {8'd0, period};
                res.qrpm = (quot > {16'd0, FullScale}) ? FullScale : quot[15:0];
                res.kind = KIND_MEASURED;
            end
        end
        return res;
    endfunction

    // Event driver: predicts at each accepted transfer, then offers the next event.
    always @(posedge aclk) begin
        tach_event_t ev;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_speeds.push_back(predict_speed(event_op_t'(s_tuser), s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    ev = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= ev.op;
                    s_tdata  <= ev.cc;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random backpressure.
    always @(posedge aclk) begin
        speed_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_speeds.size() == 0) begin
                    $display("%0t: unexpected result qrpm=%h kind=%0d", $time, m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_speeds.pop_front();
                    if (m_tdata !== want.qrpm) begin
                        $display("%0t: qrpm expected %h actual %h", $time, want.qrpm, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.kind) begin
                        $display("%0t: speed_kind expected %0d actual %0d",
                                 $time, want.kind, m_tuser);
                        mismatch_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_event(input event_op_t op, input logic [15:0] cc);
        tach_event_t ev;
        ev.op = op;
        ev.cc = cc;
        pending_events.push_back(ev);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RATE_NUM:   rate_num = val;
            CFG_MIN_PERIOD: min_per  = val[23:0];
            CFG_RAMP_NUM:   ramp_num = val[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_events.size() != 0 || s_tvalid || expected_speeds.size() != 0);
        // Let the block settle past its divider latency before touching registers.
        repeat (40) @(posedge aclk);
    endtask

    // Mostly well-formed rotation traffic: overflow ticks at each timer wrap, then
    // the capture, with occasional stops and stray events mixed in.
    task automatic gen_traffic(input int count);
        int          n;
        int          pick;
        int          d;
        int unsigned delta;
        int unsigned wraps;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                push_event(event_op_t'($urandom_range(1)), 16'($urandom));
                n++;
            end else if (pick < 6) begin
                wraps = $urandom_range(125, 135);
                repeat (wraps) push_event(OP_TICK, '0);
                tach_timer = 16'($urandom);
                push_event(OP_CAPTURE, tach_timer);
                n += wraps + 1;
            end else begin
                if (pick >= 56 && pick < 76 && min_per < 24'h100000) begin
                    d = int'(min_per) + $urandom_range(6) - 3;
                    delta = (d < 0) ? 0 : d;
                end else if (pick >= 76 && pick < 97) begin
                    delta = $urandom_range(65536, 8 * 65536);
                end else if (pick >= 97) begin
                    delta = $urandom_range(8 * 65536, 127 * 65536);
                end else begin
                    delta = $urandom_range(1, 65535);
                end
                wraps = ({16'd0, tach_timer} + delta) >> 16;
                repeat (wraps) push_event(OP_TICK, '0);
                tach_timer = tach_timer + delta[15:0];
                push_event(OP_CAPTURE, tach_timer);
                n += wraps + 1;
            end
        end
    endtask

    initial begin
        rate_num = RateNumReset;
        min_per  = MinPeriodReset;
        ramp_num = RampNumReset;
        ovf_cnt  = StopCount;
        last_cc  = '0;
        per_low  = '0;
        per_high = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at reset settings.
        send_idle_pct = 10;
        recv_idle_pct = 57;
        push_event(OP_TICK, 16'hFFFF);       // tick while stopped
        push_event(OP_CAPTURE, 16'h0000);
        push_event(OP_CAPTURE, 16'hFFFF);
        push_event(OP_CAPTURE, 16'h0000);    // wrap with no overflow in between
        push_event(OP_TICK, '0);
        push_event(OP_CAPTURE, 16'h1C9D);
        push_event(OP_CAPTURE, 16'h393A);    // period exactly at the minimum
        push_event(OP_CAPTURE, 16'h55D6);    // one below the minimum
        push_event(OP_TICK, '0);
        push_event(OP_TICK, '0);             // ramp-down bound
        push_event(OP_CAPTURE, 16'hFFFF);
        push_event(OP_TICK, '0);
        push_event(OP_CAPTURE, 16'h0001);
        wait_drained();

        // Extreme settings, plus a write to an index outside the register map.
        write_reg(CFG_RATE_NUM, 32'hFFFF_FFFF);
        write_reg(CFG_MIN_PERIOD, 32'd0);
        write_reg(CFG_RAMP_NUM, 32'h0000_FFFF);
        write_reg(CfgUnused, 32'hFFFF_FFFF);
        push_event(OP_CAPTURE, 16'h8000);
        push_event(OP_CAPTURE, 16'h8000);    // zero period with no minimum
        push_event(OP_CAPTURE, 16'h8001);    // quotient saturates
        push_event(OP_TICK, '0);
        push_event(OP_CAPTURE, 16'h7FFF);
        tach_timer = 16'h7FFF;
        gen_traffic(450);
        wait_drained();

        send_idle_pct = 57;
        recv_idle_pct = 10;
        write_reg(CFG_RATE_NUM, $urandom_range(100000000, 2000000000));
        write_reg(CFG_MIN_PERIOD, $urandom_range(1, 40000));
        write_reg(CFG_RAMP_NUM, $urandom_range(65535));
        gen_traffic(450);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_RATE_NUM, 32'd0);
        write_reg(CFG_MIN_PERIOD, 32'h00FF_FFFF);
        write_reg(CFG_RAMP_NUM, 32'd0);
        gen_traffic(225);
        wait_drained();
        write_reg(CfgUnused, 32'h0000_0000);
        write_reg(CFG_RATE_NUM, RateNumReset);
        write_reg(CFG_MIN_PERIOD, MinPeriodReset);
        write_reg(CFG_RAMP_NUM, RampNumReset);
        gen_traffic(225);
        wait_drained();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
